@@ rtl/core/lsma_pkg.sv @@
// Shared widths, reset values and register indexes of the light sensor moving average.
`default_nettype none

package lsma_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int BRIGHT_W       = 10;
  localparam int GAIN_W         = 16;
  localparam int OFFSET_W       = 24;
  localparam int PROD_W         = GAIN_W + SAMPLE_W;
  localparam int FRAC_W         = 16;
  localparam int DUTY_W         = 8;
  localparam int KNOB_SCALED_W  = SAMPLE_W + DUTY_W;
  localparam int KNOB_DIV       = 4095;
  localparam int KNOB_DIV_SH    = 12;
  localparam int IN_TDATA_W     = 2 * SAMPLE_W;
  localparam int OUT_TDATA_W    = 24;
  localparam int CFG_ADDR_W     = 8;
  localparam int CFG_DATA_W     = OFFSET_W;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd7851;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 24'd2838168;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [BRIGHT_W-1:0] bright_t;
  typedef logic [DUTY_W-1:0]          duty_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [OFFSET_W-1:0]        offset_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAIN   = 8'd0,
    CFG_OFFSET = 8'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ rtl/core/light_sensor_moving_average_top.sv @@
// Top level of the light sensor moving average with knob duty mapping.
// Path: an accepted item is registered in the ring stage, in post stages a and b, then
// in the output register. Throughput: one item per cycle unless m_tready stalls the
// output; the window memory write and the running total update happen together, with
// same-slot forwarding when the window is one deep. Reset: synchronous; the window reads
// as zero at once via per-entry valid bits; no clearing pass, so items are taken at once.
`default_nettype none

module light_sensor_moving_average_top #(
  parameter int WINDOW = 10
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // light_sample [11:0], knob_sample [23:12]
  input  wire [lsma_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // brightness_average [9:0], led_duty [17:10], zero [23:18]
  output logic [lsma_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [lsma_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire [lsma_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lsma_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TOT_W  = BRIGHT_W + SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  gain_t                    gain;
  offset_t                  offset;
  logic [SLOT_W-1:0]        write_slot;
  logic                     ring_valid;
  logic                     post_ready;
  logic signed [TOT_W-1:0]  ring_total;
  sample_t                  ring_knob;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain       <= GAIN_RESET;
      offset     <= OFFSET_RESET;
      write_slot <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_addr)
          CFG_GAIN:   gain   <= cfg_data[GAIN_W-1:0];
          CFG_OFFSET: offset <= cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + 1'b1;
      end
    end
  end

  lsma_ring #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W),
    .TOT_W  (TOT_W)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .light     (s_tdata[SAMPLE_W-1:0]),
    .knob      (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .slot      (write_slot),
    .gain      (gain),
    .offset    (offset),
    .out_valid (ring_valid),
    .out_ready (post_ready),
    .out_total (ring_total),
    .out_knob  (ring_knob)
  );

  lsma_post #(
    .WINDOW (WINDOW),
    .TOT_W  (TOT_W)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ring_valid),
    .in_ready (post_ready),
    .in_total (ring_total),
    .in_knob  (ring_knob),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/lsma_ring.sv @@
// Calibration stage with the window ring memory and the running total.
`default_nettype none

module lsma_ring #(
  parameter int WINDOW = 10,
  parameter int SLOT_W = 4,
  parameter int TOT_W  = 14
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  lsma_pkg::sample_t        light,
  input  lsma_pkg::sample_t        knob,
  input  wire [SLOT_W-1:0]         slot,
  input  lsma_pkg::gain_t          gain,
  input  lsma_pkg::offset_t        offset,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [TOT_W-1:0] out_total,
  output lsma_pkg::sample_t        out_knob
);
  import lsma_pkg::*;

  localparam int QW = PROD_W + 1;
  localparam int BW = QW - FRAC_W;
  localparam logic signed [QW-1:0] ROUND_BIAS = QW'((1 << FRAC_W) - 1);
  localparam logic signed [BW-1:0] BRIGHT_HI  = BW'(511);
  localparam logic signed [BW-1:0] BRIGHT_LO  = -BW'(512);
  localparam logic signed [TOT_W-1:0] TOT_MAX = TOT_W'(511 * WINDOW);
  localparam logic signed [TOT_W-1:0] TOT_MIN = -TOT_W'(512 * WINDOW);

  logic                     s1_valid;
  logic [PROD_W-1:0]        s1_prod;
  sample_t                  s1_knob;
  logic [SLOT_W-1:0]        s1_slot;
  logic                     in_accept;
  logic                     s1_go;

  bright_t                  mem [WINDOW];
  logic [WINDOW-1:0]        vld;
  bright_t                  rd_q;
  logic                     rd_vld;
  logic                     fwd_q;
  bright_t                  fwd_data;

  logic signed [TOT_W-1:0]  total;
  logic signed [TOT_W-1:0]  total_next;
  logic signed [QW-1:0]     q;
  logic signed [QW-1:0]     qb;
  logic signed [BW-1:0]     bq;
  bright_t                  bright;
  bright_t                  old_val;

  assign in_ready  = !s1_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign s1_go     = s1_valid && out_ready;

  // Q16 value less offset, then division by 65536 truncating toward zero, saturated to -512..511.
  always_comb begin
    q  = signed'({1'b0, s1_prod}) - signed'(QW'(offset));
    qb = q + (q[QW-1] ? ROUND_BIAS : '0);
    bq = qb[QW-1:FRAC_W];
    if (bq > BRIGHT_HI) begin
      bright = BRIGHT_HI[BRIGHT_W-1:0];
    end else if (bq < BRIGHT_LO) begin
      bright = BRIGHT_LO[BRIGHT_W-1:0];
    end else begin
      bright = bq[BRIGHT_W-1:0];
    end
  end

  assign old_val    = fwd_q ? fwd_data : (rd_vld ? rd_q : '0);
  assign total_next = total - TOT_W'(old_val) + TOT_W'(bright);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      total    <= '0;
      vld      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        total        <= total_next;
        vld[s1_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_prod  <= PROD_W'(gain) * PROD_W'(light);
      s1_knob  <= knob;
      s1_slot  <= slot;
      rd_q     <= mem[slot];
      rd_vld   <= vld[slot];
      fwd_q    <= s1_go && (s1_slot == slot);
      fwd_data <= bright;
    end
    if (s1_go) begin
      mem[s1_slot] <= bright;
    end
  end

  assign out_valid = s1_valid;
  assign out_total = total_next;
  assign out_knob  = s1_knob;

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_slot <= SLOT_W'(WINDOW - 1)))
    else $error("ring slot beyond window");

  a_fwd_only_single: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && fwd_q) |-> (WINDOW == 1))
    else $error("same-slot forwarding with a window deeper than one");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    (total >= TOT_MIN) && (total <= TOT_MAX))
    else $error("running total outside window range");

endmodule

`default_nettype wire

@@ rtl/core/lsma_post.sv @@
// Average by reciprocal multiplication, knob duty mapping and the output register.
`default_nettype none

module lsma_post #(
  parameter int WINDOW = 10,
  parameter int TOT_W  = 14
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire signed [TOT_W-1:0]             in_total,
  input  lsma_pkg::sample_t                  in_knob,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [lsma_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import lsma_pkg::*;

  localparam int AVG_SH = TOT_W + 1;
  localparam int MUL_W  = TOT_W + AVG_SH + 1;
  localparam logic [AVG_SH:0] AVG_MUL = (AVG_SH + 1)'((64'd1 << AVG_SH) / WINDOW);
  localparam logic [TOT_W-1:0] WIN_T = TOT_W'(WINDOW);
  localparam logic [KNOB_SCALED_W-1:0] KDIV_T = KNOB_SCALED_W'(KNOB_DIV);
  localparam int PAD_W = OUT_TDATA_W - BRIGHT_W - DUTY_W;

  logic                      a_valid;
  logic signed [TOT_W-1:0]   a_total;
  sample_t                   a_knob;
  logic                      b_valid;
  logic [TOT_W-1:0]          b_mag;
  logic                      b_neg;
  logic [BRIGHT_W-1:0]       b_q;
  logic [KNOB_SCALED_W-1:0]  b_x;
  duty_t                     b_dk;

  logic                      a_go;
  logic                      b_go;
  logic                      b_ready;

  logic [TOT_W-1:0]          a_mag;
  logic [MUL_W-1:0]          a_prod;
  logic [KNOB_SCALED_W-1:0]  a_x;
  logic [TOT_W-1:0]          qw;
  logic [TOT_W-1:0]          rem;
  logic [BRIGHT_W-1:0]       q_fin;
  logic [BRIGHT_W-1:0]       avg;
  logic [KNOB_SCALED_W-1:0]  dr;
  duty_t                     d_fin;

  assign b_go     = b_valid && (!m_tvalid || m_tready);
  assign b_ready  = !b_valid || b_go;
  assign a_go     = a_valid && b_ready;
  assign in_ready = !a_valid || a_go;

  // Estimates are at most one below the true quotient.
  assign a_mag  = a_total[TOT_W-1] ? TOT_W'(-a_total) : TOT_W'(a_total);
  assign a_prod = MUL_W'(a_mag) * MUL_W'(AVG_MUL);
  // Knob times 255.
  assign a_x    = KNOB_SCALED_W'({a_knob, 8'b0}) - KNOB_SCALED_W'(a_knob);

  assign qw    = TOT_W'(b_q) * WIN_T;
  assign rem   = b_mag - qw;
  assign q_fin = b_q + BRIGHT_W'(rem >= WIN_T);
  assign avg   = b_neg ? (~q_fin + 1'b1) : q_fin;

  assign dr    = b_x - (KNOB_SCALED_W'({b_dk, 12'b0}) - KNOB_SCALED_W'(b_dk));
  assign d_fin = b_dk + DUTY_W'(dr >= KDIV_T);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (!m_tvalid || m_tready) begin
        m_tvalid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_total <= in_total;
      a_knob  <= in_knob;
    end
    if (a_go) begin
      b_mag <= a_mag;
      b_neg <= a_total[TOT_W-1];
      b_q   <= a_prod[AVG_SH +: BRIGHT_W];
      b_x   <= a_x;
      b_dk  <= a_x[KNOB_DIV_SH +: DUTY_W];
    end
    if (b_go) begin
      m_tdata <= {PAD_W'(0), d_fin, avg};
    end
  end

  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> ((q_fin <= BRIGHT_W'(512)) && (b_neg || (q_fin <= BRIGHT_W'(511)))))
    else $error("window mean outside brightness range");

endmodule

`default_nettype wire
